>>> rtl/interval_set_engine_unit_assert.svh
// Assertion macros used by the checker file ise_checker.sv.
`ifndef INTERVAL_SET_ENGINE_UNIT_ASSERT_SVH
`define INTERVAL_SET_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ISE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval set engine check failed");

// Next-cycle implication, disabled during reset.
`define ISE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval set engine check failed");

`endif

>>> rtl/ise_pkg.sv
`default_nettype none
package ise_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 2);
  localparam int CP_W       = 21;
  localparam int ADDR_W     = IDX_W + 1;
  localparam logic [CP_W-1:0] CSM_RESET = 21'd1114111;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_NEGATE = 2'd2,
    OP_QUERY  = 2'd3
  } ise_op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } ise_status_t;

  localparam logic [0:0] REG_CODE_SPACE_MAX = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_WALK,
    S_WALK2,
    S_FIN,
    S_RESP
  } ise_state_t;

  typedef struct packed {
    logic [1:0]      operation;
    logic [CP_W-1:0] range_low;
    logic [CP_W-1:0] range_high;
  } ise_in_t;

  typedef struct packed {
    logic            in_set;
    logic [1:0]      status;
    logic [6:0]      range_count;
  } ise_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic walk;
    logic second;
    logic advance;
    logic fin;
    logic finish;
  } ise_cmd_t;

  typedef struct packed {
    logic invalid;
    logic empty;
    logic need_two;
    logic last;
  } ise_stat_t;

endpackage
`default_nettype wire

>>> rtl/ise_ctrl.sv
`default_nettype none
module ise_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ise_pkg::ise_stat_t stat,
  output ise_pkg::ise_cmd_t      cmd
);
  import ise_pkg::*;

  ise_state_t state, state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        if (stat.invalid) state_next = S_RESP;
        else if (stat.empty) state_next = S_FIN;
        else state_next = S_WALK;
      end
      S_WALK: begin
        if (stat.need_two) state_next = S_WALK2;
        else if (stat.last) state_next = S_FIN;
      end
      S_WALK2: begin
        if (stat.last) state_next = S_FIN;
        else state_next = S_WALK;
      end
      S_FIN:  state_next = S_RESP;
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      S_PREP: cmd.prep = 1'b1;
      S_WALK: begin
        cmd.walk    = 1'b1;
        cmd.advance = !stat.need_two && !stat.last;
      end
      S_WALK2: begin
        cmd.second  = 1'b1;
        cmd.advance = !stat.last;
      end
      S_FIN:  cmd.fin = 1'b1;
      S_RESP: cmd.finish = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ise_dpath.sv
`default_nettype none
module ise_dpath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ise_pkg::ise_in_t       in_data,
  input  wire logic [ise_pkg::CP_W-1:0] csm,
  input  wire ise_pkg::ise_cmd_t      cmd,
  output ise_pkg::ise_stat_t          stat,
  output ise_pkg::ise_out_t           out_data
);
  import ise_pkg::*;

  // Two banks: the current table is read from one while the new one is
  // written into the other; a committed insert, remove or negate flips the bank.
  logic [2*CP_W-1:0] mem [2*MAX_RANGES];
  logic [2*CP_W-1:0] rd_word;

  ise_op_t         op;
  logic            inv;
  logic [CP_W:0]   wlo, whi;
  logic            placed, stop, hit, bank;
  logic [IDX_W-1:0] idx, idx_rd;
  logic [CNT_W-1:0] cnt, used;
  logic [CP_W:0]   el, eh, csm_x;
  logic            below, above, overlap;
  logic            emit;
  logic [CP_W:0]   e_lo, e_hi;
  logic            writes, commit;

  assign el    = {1'b0, rd_word[2*CP_W-1:CP_W]};
  assign eh    = {1'b0, rd_word[CP_W-1:0]};
  assign csm_x = {1'b0, csm};

  assign below   = (eh + 1'b1) < wlo;
  assign above   = el > (whi + 1'b1);
  assign overlap = !(eh < wlo || el > whi);

  assign idx_rd = cmd.prep ? '0 : (cmd.advance ? idx + 1'b1 : idx);

  assign stat.invalid  = inv;
  assign stat.empty    = (used == '0);
  assign stat.last     = ({1'b0, idx} + 1'b1) == used;
  assign stat.need_two = (op == OP_INSERT && !below && above && !placed) ||
                         (op == OP_REMOVE && overlap && el < wlo && eh > whi);

  always_comb begin
    emit = 1'b0;
    e_lo = el;
    e_hi = eh;
    if (cmd.walk) begin
      case (op)
        OP_INSERT: begin
          if (below) emit = 1'b1;
          else if (above) begin
            emit = 1'b1;
            if (!placed) begin
              e_lo = wlo;
              e_hi = whi;
            end
          end
        end
        OP_REMOVE: begin
          if (!overlap) emit = 1'b1;
          else if (el < wlo) begin
            emit = 1'b1;
            e_hi = wlo - 1'b1;
          end else if (eh > whi) begin
            emit = 1'b1;
            e_lo = whi + 1'b1;
          end
        end
        OP_NEGATE: begin
          if (!stop && el <= csm_x && wlo < el) begin
            emit = 1'b1;
            e_lo = wlo;
            e_hi = el - 1'b1;
          end
        end
        default: emit = 1'b0;
      endcase
    end else if (cmd.second) begin
      emit = 1'b1;
      if (op == OP_REMOVE) e_lo = whi + 1'b1;
    end else if (cmd.fin) begin
      e_lo = wlo;
      e_hi = (op == OP_NEGATE) ? csm_x : whi;
      emit = (op == OP_INSERT && !placed) || (op == OP_NEGATE && wlo <= csm_x);
    end
  end

  assign writes = !inv && op != OP_QUERY;
  assign commit = writes && cnt <= CNT_W'(MAX_RANGES);

  always_ff @(posedge clk) begin
    rd_word <= mem[{bank, idx_rd}];
    if (emit && cnt < CNT_W'(MAX_RANGES))
      mem[{~bank, cnt[IDX_W-1:0]}] <= {e_lo[CP_W-1:0], e_hi[CP_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      bank <= 1'b0;
    end else if (cmd.finish && commit) begin
      used <= cnt;
      bank <= ~bank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= ise_op_t'(in_data.operation);
      inv    <= (in_data.operation == OP_INSERT || in_data.operation == OP_REMOVE) &&
                (in_data.range_low > in_data.range_high);
      wlo    <= (in_data.operation == OP_NEGATE) ? '0 : {1'b0, in_data.range_low};
      whi    <= {1'b0, in_data.range_high};
      placed <= 1'b0;
      stop   <= 1'b0;
      hit    <= 1'b0;
      cnt    <= '0;
    end else begin
      if (emit) cnt <= cnt + 1'b1;
      if (cmd.walk) begin
        case (op)
          OP_INSERT: begin
            if (above) placed <= 1'b1;
            else if (!below) begin
              if (el < wlo) wlo <= el;
              if (eh > whi) whi <= eh;
            end
          end
          OP_NEGATE: begin
            if (!stop) begin
              if (el > csm_x) stop <= 1'b1;
              else wlo <= eh + 1'b1;
            end
          end
          OP_QUERY: begin
            if (el <= wlo && wlo <= eh) hit <= 1'b1;
          end
          default: hit <= hit;
        endcase
      end
    end
    if (cmd.prep) idx <= '0;
    else if (cmd.advance) idx <= idx + 1'b1;
    if (cmd.finish) begin
      out_data.in_set      <= (op == OP_QUERY) && hit;
      out_data.status      <= inv ? ST_INVALID : (writes && !commit) ? ST_FULL : ST_DONE;
      out_data.range_count <= 7'(commit ? cnt : used);
    end
  end

endmodule
`default_nettype wire

>>> rtl/interval_set_engine_unit.sv
`default_nettype none
// Interval set engine: keeps a set of code points as an ascending table of
// disjoint, non-adjacent ranges and applies one operation per input word.
// The input channel (in_valid, in_ready, in_data) carries insert, remove,
// negate or query words; the output channel (out_valid, out_ready, out_data)
// returns exactly one word per input word with the membership bit, a status
// and the number of stored ranges afterwards.
// An operation walks the stored table once, one entry per cycle, reading the
// current bank of a two-bank table memory and writing the new table into the
// other bank; the walk is held at an entry when that entry is split or an
// inserted range lands ahead of it. The table memory has a single read port.
// An empty table skips the walk, and an invalid range skips both the walk and
// the final write step. The next word is accepted in the idle state, after the
// result is written.
// A finished result sits in an output register, so a stalled receiver only
// holds the block once the next result is ready to be written there.
// Reset empties the set and sets code_space_max to 1114111; no clearing pass
// is needed. code_space_max lives at APB byte address 0.
module interval_set_engine_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ise_pkg::ise_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ise_pkg::ise_out_t      out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import ise_pkg::*;

  logic [CP_W-1:0] csm;
  ise_cmd_t        cmd;
  ise_stat_t       stat;
  logic            reg_hit;

  // Only word 0 is a register; the byte offset bits are ignored.
  assign reg_hit = (paddr[2] == REG_CODE_SPACE_MAX);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(32-CP_W){1'b0}}, csm} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      csm <= CSM_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      csm <= pwdata[CP_W-1:0];
    end
  end

  ise_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ise_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .csm      (csm),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/ise_checker.sv
`default_nettype none
`include "interval_set_engine_unit_assert.svh"
module ise_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             in_ready,
  input wire ise_pkg::ise_out_t out_data
);
  import ise_pkg::*;

  `ISE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ISE_ASSERT_NOW(a_status_code, out_valid, out_data.status != 2'd3)
  `ISE_ASSERT_NOW(a_count_range, out_valid, out_data.range_count <= 7'(MAX_RANGES))
  `ISE_ASSERT_NOW(a_member_done, out_valid && out_data.in_set,
                  out_data.status == ST_DONE && out_data.range_count != 7'd0)

  logic unused;
  assign unused = in_ready;

endmodule

bind interval_set_engine_unit ise_checker u_ise_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .in_ready  (in_ready),
  .out_data  (out_data)
);
`default_nettype wire

>>> tb/tb_interval_set_engine_unit.sv
`default_nettype none
module tb_interval_set_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ise_pkg::*;

  // Limits for the watchdog and for the quiet period before a register write.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 2 * MAX_RANGES + 20;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  ise_in_t         in_data;
  logic            out_valid;
  logic            out_ready;
  ise_out_t        out_data;
  logic            psel;
  logic            penable;
  logic            pwrite;
  logic [2:0]      paddr;
  logic [31:0]     pwdata;
  logic [31:0]     prdata;
  logic            pready;

  interval_set_engine_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // The predicted set, kept as an ascending table of disjoint, non-adjacent
  // ranges, exactly as the block is meant to store it.
  logic [CP_W-1:0] set_lo [$];
  logic [CP_W-1:0] set_hi [$];
  logic [CP_W-1:0] space_max;

  // Result words still owed by the block, oldest first.
  ise_out_t        owed_words [$];

  int              mismatches;
  int              idle_cycles;
  int              send_idle_pct;
  int              recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the new table for one operation and the word the block owes.
  // Arithmetic is done at 32 bits so that high + 1 never wraps to zero.
  function automatic ise_out_t predict_word(ise_in_t w);
    ise_out_t        r;
    logic [CP_W-1:0] nl [$];
    logic [CP_W-1:0] nh [$];
    int unsigned     lo, hi, el, eh, b;
    bit              placed;
    bit              stop;
    r = '0;
    lo = 32'(w.range_low);
    hi = 32'(w.range_high);
    placed = 1'b0;
    stop = 1'b0;
    b = 0;
    if (ise_op_t'(w.operation) == OP_QUERY) begin
      for (int i = 0; i < set_lo.size(); i++) begin
        if (!stop) begin
          if (lo < 32'(set_lo[i])) begin
            stop = 1'b1;
          end else if (lo <= 32'(set_hi[i])) begin
            r.in_set = 1'b1;
            stop = 1'b1;
          end
        end
      end
    end else if (ise_op_t'(w.operation) != OP_NEGATE && lo > hi) begin
      r.status = ST_INVALID;
    end else begin
      for (int i = 0; i < set_lo.size(); i++) begin
        el = 32'(set_lo[i]);
        eh = 32'(set_hi[i]);
        case (ise_op_t'(w.operation))
          OP_INSERT: begin
            if (eh + 1 < lo) begin
              nl.push_back(CP_W'(el)); nh.push_back(CP_W'(eh));
            end else if (el > hi + 1) begin
              if (!placed) begin
                nl.push_back(CP_W'(lo)); nh.push_back(CP_W'(hi));
                placed = 1'b1;
              end
              nl.push_back(CP_W'(el)); nh.push_back(CP_W'(eh));
            end else begin
              if (el < lo) lo = el;
              if (eh > hi) hi = eh;
            end
          end
          OP_REMOVE: begin
            if (eh < lo || el > hi) begin
              nl.push_back(CP_W'(el)); nh.push_back(CP_W'(eh));
            end else begin
              if (el < lo) begin
                nl.push_back(CP_W'(el)); nh.push_back(CP_W'(lo - 1));
              end
              if (eh > hi) begin
                nl.push_back(CP_W'(hi + 1)); nh.push_back(CP_W'(eh));
              end
            end
          end
          default: begin
            // Negate: entries above the code space end are dropped.
            if (!stop) begin
              if (el > 32'(space_max)) begin
                stop = 1'b1;
              end else begin
                if (b < el) begin
                  nl.push_back(CP_W'(b)); nh.push_back(CP_W'(el - 1));
                end
                b = eh + 1;
              end
            end
          end
        endcase
      end
      if (ise_op_t'(w.operation) == OP_INSERT && !placed) begin
        nl.push_back(CP_W'(lo)); nh.push_back(CP_W'(hi));
      end
      if (ise_op_t'(w.operation) == OP_NEGATE && b <= 32'(space_max)) begin
        nl.push_back(CP_W'(b)); nh.push_back(space_max);
      end
      if (nl.size() > MAX_RANGES) begin
        r.status = ST_FULL;
      end else begin
        set_lo = nl;
        set_hi = nh;
      end
    end
    r.range_count = 7'(set_lo.size());
    return r;
  endfunction

  // Send one word, holding valid until it is taken. Valid is only dropped
  // when the sender idles first; otherwise the next word follows directly.
  task automatic send_word(ise_op_t op, int unsigned lo, int unsigned hi);
    ise_in_t w;
    w = '{operation: op, range_low: CP_W'(lo), range_high: CP_W'(hi)};
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    owed_words.push_back(predict_word(w));
  endtask

  // Wait until every owed word has come back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write over APB: a setup cycle and then an access cycle,
  // followed by a read back of the same register.
  task automatic write_space_max(int unsigned value);
    drain();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_CODE_SPACE_MAX);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    space_max = CP_W'(value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {{(32-CP_W){1'b0}}, space_max}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register read mismatch: expected %0d, got %0d", space_max, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int unsigned rand_point();
    case ($urandom_range(3))
      0: return $urandom_range(1114111);
      1: return $urandom_range(2097151);
      default: return $urandom_range(300);
    endcase
  endfunction

  // Directed words: field extremes, every operation and the special cases.
  task automatic test_directed();
    send_word(OP_NEGATE, 0, 0);                 // negate of the empty set
    send_word(OP_QUERY, 0, 0);
    send_word(OP_QUERY, 1114111, 0);
    send_word(OP_NEGATE, 2097151, 2097151);     // set covering all: empty
    send_word(OP_INSERT, 10, 5);                // invalid range
    send_word(OP_REMOVE, 2097151, 0);           // invalid range
    send_word(OP_INSERT, 2097151, 2097151);     // above the code space
    send_word(OP_INSERT, 0, 0);
    send_word(OP_INSERT, 2, 4);
    send_word(OP_INSERT, 1, 1);                 // touching ranges merge
    send_word(OP_QUERY, 4, 0);
    send_word(OP_QUERY, 5, 0);
    send_word(OP_REMOVE, 2, 2);                 // splits an entry
    send_word(OP_NEGATE, 0, 0);                 // drops the high entry
    send_word(OP_REMOVE, 0, 2097151);
    // Fill the table with isolated points until it overflows.
    for (int i = 0; i < MAX_RANGES + 1; i++) send_word(OP_INSERT, 4 * i, 4 * i);
    send_word(OP_REMOVE, 1, 1);
    send_word(OP_INSERT, 253, 254);             // widens the last entry
    send_word(OP_REMOVE, 253, 253);             // split would overflow
    send_word(OP_REMOVE, 0, 0);
    send_word(OP_INSERT, 300, 300);
    send_word(OP_NEGATE, 0, 0);                 // complement overflows while code_space_max is 1114111
    send_word(OP_REMOVE, 0, 2097151);
  endtask

  // Random words, mostly well-formed, with a bias toward a crowded table.
  task automatic test_random(int count);
    int unsigned lo, hi;
    int          pick;
    for (int i = 0; i < count; i++) begin
      lo = rand_point();
      hi = ($urandom_range(9) == 0) ? rand_point() : lo + $urandom_range(6);
      if (hi > 2097151) hi = 2097151;
      pick = $urandom_range(99);
      if (pick < 40) send_word(OP_INSERT, lo, hi);
      else if (pick < 62) send_word(OP_REMOVE, lo, hi);
      else if (pick < 67) send_word(OP_NEGATE, rand_point(), rand_point());
      else send_word(OP_QUERY, lo, rand_point());
      if ($urandom_range(199) == 0) send_word(OP_REMOVE, 0, 2097151);
    end
  endtask

  // Receiver: random stalls, and a field-by-field check of each word taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %p", out_data);
        end else begin
          if (out_data.in_set !== owed_words[0].in_set ||
              out_data.status !== owed_words[0].status ||
              out_data.range_count !== owed_words[0].range_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", owed_words[0], out_data);
          end
          void'(owed_words.pop_front());
        end
      end
      out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a word and no register access runs.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    space_max = CSM_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    write_space_max(0);
    test_directed();
    write_space_max(2097151);
    send_idle_pct = 81;
    test_random(110);
    write_space_max(300);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    test_random(110);
    write_space_max(1114111);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    test_random(110);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(110);

    drain();
    if (mismatches == 0 && owed_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/ise_pkg.sv
rtl/ise_ctrl.sv
rtl/ise_dpath.sv
rtl/interval_set_engine_unit.sv
rtl/ise_checker.sv
tb/tb_interval_set_engine_unit.sv
